FILE: hdl/srr_pkg.sv
// shared types and constants for the selective repeat receiver
// no dependencies; used by every module of the block
`default_nettype none

package srr_pkg;

    localparam int DEF_MAX_WINDOW = 16;
    localparam int DEF_SEQ_BITS   = 32;
    localparam int WIN_W          = 5;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 5'd4;

    typedef enum logic [1:0] {
        EV_NAK     = 2'd0,
        EV_ACK     = 2'd1,
        EV_DELIVER = 2'd2
    } ev_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DELIVER,
        ST_ACK
    } back_state_t;

    typedef struct packed {
        logic        is_data;
        logic        bit_error;
        logic [31:0] seq_num;
    } in_word_t;

    typedef struct packed {
        ev_kind_t    event_kind;
        logic [31:0] frame_number;
        logic        last_of_run;
    } out_word_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

FILE: hdl/srr_front.sv
// front stage: takes frames, drops corrupted and non-data ones
// depends on srr_pkg
`default_nettype none

module srr_front #(
    parameter int SEQ_BITS = srr_pkg::DEF_SEQ_BITS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire srr_pkg::in_word_t     in_data,
    input  wire srr_pkg::q_status_t    q_status,
    output logic                       push,
    output logic [SEQ_BITS-1:0]        push_data
);

    logic                front_valid_reg;
    logic                front_valid_next;
    logic [SEQ_BITS-1:0] front_seq_reg;
    logic [SEQ_BITS-1:0] front_seq_next;
    logic                accept;

    assign in_stall  = front_valid_reg && q_status.full;
    assign accept    = in_valid && !in_stall;
    assign push      = front_valid_reg && !q_status.full;
    assign push_data = front_seq_reg;

    always_comb
    begin
        front_valid_next = front_valid_reg;
        front_seq_next   = front_seq_reg;
        if (accept)
        begin
            // only clean data frames go on to the window logic
            front_valid_next = in_data.is_data && !in_data.bit_error;
            front_seq_next   = in_data.seq_num[SEQ_BITS-1:0];
        end
        else if (push)
        begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_seq_reg <= front_seq_next;
    end

endmodule

`default_nettype wire

FILE: hdl/srr_queue.sv
// short fifo of sequence numbers between front and back
// depends on srr_pkg
`default_nettype none

module srr_queue #(
    parameter int WIDTH = srr_pkg::DEF_SEQ_BITS,
    parameter int DEPTH = srr_pkg::QUEUE_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire logic [WIDTH-1:0]   push_data,
    input  wire logic               pop,
    output logic [WIDTH-1:0]        pop_data,
    output srr_pkg::q_status_t      status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/srr_back.sv
// back end: window test, nak, in-order delivery and cumulative ack
// depends on srr_pkg; arrival bits are kept relative to the expected number
`default_nettype none

module srr_back #(
    parameter int MAX_WINDOW = srr_pkg::DEF_MAX_WINDOW,
    parameter int SEQ_BITS   = srr_pkg::DEF_SEQ_BITS
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire srr_pkg::q_status_t         q_status,
    input  wire logic [SEQ_BITS-1:0]        q_data,
    output logic                            q_pop,
    input  wire logic [srr_pkg::WIN_W-1:0]  window,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output srr_pkg::out_word_t              out_data
);

    srr_pkg::back_state_t state_reg;
    srr_pkg::back_state_t state_next;
    logic [SEQ_BITS-1:0]   seq_reg;
    logic [SEQ_BITS-1:0]   seq_next;
    logic [SEQ_BITS-1:0]   exp_reg;
    logic [SEQ_BITS-1:0]   exp_next;
    logic [MAX_WINDOW-1:0] map_reg;
    logic [MAX_WINDOW-1:0] map_next;
    logic                  nak_armed_reg;
    logic                  nak_armed_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    srr_pkg::out_word_t    out_data_reg;
    srr_pkg::out_word_t    out_data_next;

    logic                         out_free;
    logic [srr_pkg::WIN_W-1:0]    win;
    logic [SEQ_BITS-1:0]          offset;
    logic                         in_win;
    logic                         is_old;
    logic [MAX_WINDOW-1:0]        set_mask;
    logic [MAX_WINDOW-1:0]        map_shift;
    logic [SEQ_BITS-1:0]          exp_inc;
    logic [SEQ_BITS-1:0]          exp_dec;
    logic                         exp_nonzero;
    logic                         inc_nonzero;
    logic                         emit;
    srr_pkg::ev_kind_t            emit_kind;
    logic [SEQ_BITS-1:0]          emit_number;
    logic                         emit_last;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    assign win = (32'(window) > 32'(MAX_WINDOW)) ? srr_pkg::WIN_W'(MAX_WINDOW) : window;
    assign offset      = seq_reg - exp_reg;
    assign in_win      = offset < SEQ_BITS'(win);
    assign is_old      = seq_reg < exp_reg;
    assign map_shift   = map_reg >> 1;
    assign exp_inc     = exp_reg + 1'b1;
    assign exp_dec     = exp_reg - 1'b1;
    assign exp_nonzero = |exp_reg;
    assign inc_nonzero = |exp_inc;

    always_comb
    begin
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            set_mask[i] = (offset == SEQ_BITS'(i));
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        seq_next       = seq_reg;
        exp_next       = exp_reg;
        map_next       = map_reg;
        nak_armed_next = nak_armed_reg;
        q_pop          = 1'b0;
        emit           = 1'b0;
        emit_kind      = srr_pkg::EV_ACK;
        emit_number    = exp_dec;
        emit_last      = 1'b1;

        unique case (state_reg)
            srr_pkg::ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    q_pop      = 1'b1;
                    seq_next   = q_data;
                    state_next = srr_pkg::ST_EVAL;
                end
            end
            srr_pkg::ST_EVAL:
            begin
                if (out_free)
                begin
                    if (in_win)
                    begin
                        map_next = map_reg | set_mask;
                        if (offset != '0)
                        begin
                            // frame ahead of the gap: one nak until delivery moves on
                            if (nak_armed_reg)
                            begin
                                emit           = 1'b1;
                                emit_kind      = srr_pkg::EV_NAK;
                                emit_number    = exp_reg;
                                emit_last      = !exp_nonzero;
                                nak_armed_next = 1'b0;
                            end
                            state_next = exp_nonzero ? srr_pkg::ST_ACK : srr_pkg::ST_IDLE;
                        end
                        else
                        begin
                            state_next = srr_pkg::ST_DELIVER;
                        end
                    end
                    else if (is_old)
                    begin
                        // duplicate of a delivered frame: repeat the ack
                        emit       = 1'b1;
                        state_next = srr_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = srr_pkg::ST_IDLE;
                    end
                end
            end
            srr_pkg::ST_DELIVER:
            begin
                if (out_free)
                begin
                    emit           = 1'b1;
                    emit_kind      = srr_pkg::EV_DELIVER;
                    emit_number    = exp_reg;
                    emit_last      = !map_shift[0] && !inc_nonzero;
                    map_next       = map_shift;
                    exp_next       = exp_inc;
                    nak_armed_next = 1'b1;
                    if (map_shift[0])
                    begin
                        state_next = srr_pkg::ST_DELIVER;
                    end
                    else
                    begin
                        state_next = inc_nonzero ? srr_pkg::ST_ACK : srr_pkg::ST_IDLE;
                    end
                end
            end
            srr_pkg::ST_ACK:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = srr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = srr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_free)
        begin
            out_valid_next = emit;
            if (emit)
            begin
                out_data_next.event_kind   = emit_kind;
                out_data_next.frame_number = 32'(emit_number);
                out_data_next.last_of_run  = emit_last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srr_pkg::ST_IDLE;
            exp_reg       <= '0;
            map_reg       <= '0;
            nak_armed_reg <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            exp_reg       <= exp_next;
            map_reg       <= map_next;
            nak_armed_reg <= nak_armed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seq_reg      <= seq_next;
        out_data_reg <= out_data_next;
    end

`ifndef ASSERT_OFF
    a_ack_needs_number: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == srr_pkg::ST_ACK |-> exp_reg != '0)
        else $error("ack pending with no cumulative number");

    a_deliver_has_frame: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == srr_pkg::ST_DELIVER |-> map_reg[0])
        else $error("delivering a frame that has not arrived");

    a_deliver_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == srr_pkg::ST_DELIVER && out_free)
        |=> exp_reg == SEQ_BITS'($past(exp_reg) + 1'b1))
        else $error("expected number did not advance on delivery");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == srr_pkg::ST_IDLE && !q_status.empty))
        else $error("queue popped while busy");
`endif

endmodule

`default_nettype wire

FILE: hdl/selective_repeat_receiver.sv
// an accepted data frame passes the front register and the queue to the back end, whose
//   eval state registers a nak or repeated ack word and whose deliver and ack states
//   register deliveries and the trailing ack; the back end handles one frame at a time,
//   deliver repeating per delivered frame and ack trailing a frame inside the window
// dropped frames (corrupted or not data) never leave the front stage
// reset: arrival bits cleared, expected number 0, nak armed, window 4
`default_nettype none

module selective_repeat_receiver #(
    parameter int MAX_WINDOW = srr_pkg::DEF_MAX_WINDOW,
    parameter int SEQ_BITS   = srr_pkg::DEF_SEQ_BITS
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire srr_pkg::in_word_t          in_data,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output srr_pkg::out_word_t              out_data,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [srr_pkg::WIN_W-1:0]  cfg_data
);

    logic [srr_pkg::WIN_W-1:0] window_reg;
    logic [srr_pkg::WIN_W-1:0] window_next;
    srr_pkg::q_status_t        q_status;
    logic                      push;
    logic [SEQ_BITS-1:0]       push_data;
    logic                      q_pop;
    logic [SEQ_BITS-1:0]       q_data;

    assign cfg_ready   = 1'b1;
    assign window_next = (cfg_valid && cfg_ready) ? cfg_data : window_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= srr_pkg::WINDOW_RESET;
        end
        else
        begin
            window_reg <= window_next;
        end
    end

    srr_front #(
        .SEQ_BITS (SEQ_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    srr_queue #(
        .WIDTH (SEQ_BITS),
        .DEPTH (srr_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (q_pop),
        .pop_data  (q_data),
        .status    (q_status)
    );

    srr_back #(
        .MAX_WINDOW (MAX_WINDOW),
        .SEQ_BITS   (SEQ_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .window    (window_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
